// ===== rtl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants for the point-in-polygon-set block
// Holds the command and result beat layouts, the operation codes and the
// fixed coordinate and result widths.
// ----------------------------------------------------------------------------
package pic_pkg;

    // Coordinate width, signed Q12.4.
    localparam int CW    = 16;
    // Width of the reported brush index.
    localparam int HIT_W = 4;

    // Operation codes.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Command beat.
    typedef struct packed {
        logic [1:0]           operation;
        logic signed [CW-1:0] coord_x;
        logic signed [CW-1:0] coord_y;
        logic                 closes_brush;
    } t_pic_in;

    // Result beat.
    typedef struct packed {
        logic             inside_res;
        logic [HIT_W-1:0] first_brush_hit;
        logic             overflow;
    } t_pic_out;

    // One stored vertex or a query point.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_vtx;

    // Edge test result between the edge unit and the sequencer.
    typedef struct packed {
        logic valid;
        logic outside;
    } t_edge_res;

endpackage

// ===== rtl/pic_edge_test.sv =====
// ----------------------------------------------------------------------------
// pic_edge_test: two-stage half-plane test of a point against one edge
// Stage one forms both exact products of the edge normal with the point
// offset; stage two adds them and flags a negative sum as outside.
// ----------------------------------------------------------------------------
module pic_edge_test
    import pic_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_vtx      i_pt,
    input  t_vtx      i_v1,
    input  t_vtx      i_v2,
    output t_edge_res o_res
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 2;

    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic signed [DW-1:0] w_nx;
    logic signed [DW-1:0] w_ny;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic                 r_valid;
    logic [PW:0]          w_sum;

    // Offsets from the edge start and the edge normal (y1-y2, x2-x1).
    assign w_dx = {i_pt.x[CW-1], i_pt.x} - {i_v1.x[CW-1], i_v1.x};
    assign w_dy = {i_pt.y[CW-1], i_pt.y} - {i_v1.y[CW-1], i_v1.y};
    assign w_ny = {i_v1.y[CW-1], i_v1.y} - {i_v2.y[CW-1], i_v2.y};
    assign w_nx = {i_v2.x[CW-1], i_v2.x} - {i_v1.x[CW-1], i_v1.x};

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_p1 <= w_dx * w_ny;
        r_p2 <= w_dy * w_nx;
    end

    // Exact sum; the point is outside when it is negative.
    assign w_sum         = {r_p1[PW-1], r_p1} + {r_p2[PW-1], r_p2};
    assign o_res.valid   = r_valid;
    assign o_res.outside = w_sum[PW];

endmodule

// ===== rtl/point_in_convex_polygon_set.sv =====
// ----------------------------------------------------------------------------
// point_in_convex_polygon_set: point-in-model test over convex brushes
// Clear and append commands complete in the cycle they are accepted and never
// raise busy. A query raises busy and walks the closed brushes in order, one
// stored vertex read per cycle from the vertex memory: each brush takes a brush
// table read, n + 1 vertex reads for a brush of n vertices, an edge pipeline
// drain and the decision, and the walk stops at the first brush that contains
// the point. A query over an empty model answers without raising busy. The result
// is shown for exactly one cycle on o_valid, together with the sticky overflow
// flag; the receiver has no way to hold it off. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module point_in_convex_polygon_set
    import pic_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_BRUSHES  = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_pic_in  i_cmd,
    output logic     o_valid,
    output t_pic_out o_res
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int BAW = (MAX_BRUSHES > 1) ? $clog2(MAX_BRUSHES) : 1;
    localparam int BCW = $clog2(MAX_BRUSHES + 1);

    typedef struct packed {
        logic [VAW-1:0] first;
        logic [VCW-1:0] count;
    } t_brush;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BRD,
        S_BLAT,
        S_VRD,
        S_D1,
        S_D2,
        S_DEC
    } t_state;

    // Memories.
    t_vtx   r_vmem [MAX_VERTICES];
    t_brush r_bmem [MAX_BRUSHES];

    t_state         r_state;
    logic [VCW-1:0] r_vt;
    logic [VCW-1:0] r_ob;
    logic [BCW-1:0] r_bt;
    logic           r_ovf;
    t_vtx           r_pt;
    logic [BAW-1:0] r_b;
    t_brush         r_brq;
    logic [VAW-1:0] r_vaddr;
    logic [VAW-1:0] r_first;
    logic [VCW:0]   r_left;
    logic           r_prime;
    t_vtx           r_vq;
    logic           r_vq_valid;
    logic           r_vq_prime;
    t_vtx           r_prev;
    logic           r_all_in;
    logic           r_out_valid;
    t_pic_out       r_out;

    logic           w_accept;
    logic           w_append;
    logic           w_full;
    logic [VCW-1:0] w_vt_in;
    logic [VCW-1:0] n_vt;
    logic [VCW-1:0] n_ob;
    logic [BCW-1:0] n_bt;
    logic           n_ovf;
    logic           w_bwr;
    t_brush         w_bentry;
    logic [VCW:0]   w_last;
    logic           w_last_brush;
    t_vtx           w_cmd_pt;
    t_edge_res      w_edge;
    logic [31:0]    w_hit_ext;

    assign w_accept = start && !busy;
    assign w_append = w_accept && (i_cmd.operation == OP_APPEND);
    assign w_cmd_pt = '{x: i_cmd.coord_x, y: i_cmd.coord_y};

    // Append bookkeeping: vertex store, brush close and overflow.
    always_comb begin
        w_full   = (r_vt >= VCW'(MAX_VERTICES));
        w_vt_in  = w_full ? r_vt : r_vt + VCW'(1);
        n_vt     = w_vt_in;
        n_ob     = r_ob;
        n_bt     = r_bt;
        n_ovf    = r_ovf | w_full;
        w_bwr    = 1'b0;
        w_bentry = '{first: r_ob[VAW-1:0], count: w_vt_in - r_ob};
        if (i_cmd.closes_brush && (w_vt_in > r_ob)) begin
            if (r_bt < BCW'(MAX_BRUSHES)) begin
                w_bwr = 1'b1;
                n_bt  = r_bt + BCW'(1);
                n_ob  = w_vt_in;
            end else begin
                n_ovf = 1'b1;
                n_vt  = r_ob;
            end
        end
    end

    // Address of the brush's last vertex, which starts its first edge.
    assign w_last       = {1'b0, r_brq.count} + (VCW + 1)'(r_brq.first) - (VCW + 1)'(1);
    assign w_last_brush = ((BCW'(r_b) + BCW'(1)) == r_bt);
    assign w_hit_ext    = 32'(r_b);

    // Vertex memory: one write port for appends, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_append && !w_full) begin
            r_vmem[r_vt[VAW-1:0]] <= w_cmd_pt;
        end
        if (r_state == S_VRD) begin
            r_vq <= r_vmem[r_vaddr];
        end
    end

    // Brush table memory.
    always_ff @(posedge i_clk) begin
        if (w_append && w_bwr) begin
            r_bmem[r_bt[BAW-1:0]] <= w_bentry;
        end
        if (r_state == S_BRD) begin
            r_brq <= r_bmem[r_b];
        end
    end

    // Edge test pipeline.
    pic_edge_test u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vq_valid && !r_vq_prime),
        .i_pt    (r_pt),
        .i_v1    (r_prev),
        .i_v2    (r_vq),
        .o_res   (w_edge)
    );

    // Sequencer, model bookkeeping and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vt        <= '0;
            r_ob        <= '0;
            r_bt        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_vq_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_vq_valid  <= (r_state == S_VRD);
            r_vq_prime  <= r_prime;
            if (r_vq_valid) begin
                r_prev <= r_vq;
            end
            if (w_edge.valid && w_edge.outside) begin
                r_all_in <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_cmd.operation)
                            OP_CLEAR: begin
                                r_vt  <= '0;
                                r_ob  <= '0;
                                r_bt  <= '0;
                                r_ovf <= 1'b0;
                            end
                            OP_APPEND: begin
                                r_vt  <= n_vt;
                                r_ob  <= n_ob;
                                r_bt  <= n_bt;
                                r_ovf <= n_ovf;
                            end
                            OP_QUERY: begin
                                r_pt <= w_cmd_pt;
                                r_b  <= '0;
                                if (r_bt == '0) begin
                                    r_out_valid <= 1'b1;
                                    r_out       <= '{inside_res: 1'b0,
                                                     first_brush_hit: '0,
                                                     overflow: r_ovf};
                                end else begin
                                    r_state <= S_BRD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_BRD: begin
                    r_state <= S_BLAT;
                end
                S_BLAT: begin
                    r_vaddr  <= w_last[VAW-1:0];
                    r_first  <= r_brq.first;
                    r_left   <= {1'b0, r_brq.count} + (VCW + 1)'(1);
                    r_prime  <= 1'b1;
                    r_all_in <= 1'b1;
                    r_state  <= S_VRD;
                end
                S_VRD: begin
                    r_prime <= 1'b0;
                    r_vaddr <= r_prime ? r_first : r_vaddr + VAW'(1);
                    r_left  <= r_left - (VCW + 1)'(1);
                    if (r_left == (VCW + 1)'(1)) begin
                        r_state <= S_D1;
                    end
                end
                S_D1: begin
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_all_in) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{inside_res: 1'b1,
                                         first_brush_hit: w_hit_ext[HIT_W-1:0],
                                         overflow: r_ovf};
                        r_state     <= S_IDLE;
                    end else if (w_last_brush) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{inside_res: 1'b0,
                                         first_brush_hit: '0,
                                         overflow: r_ovf};
                        r_state     <= S_IDLE;
                    end else begin
                        r_b     <= r_b + BAW'(1);
                        r_state <= S_BRD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ===== rtl/pic_checker.sv =====
// ----------------------------------------------------------------------------
// pic_checker: port-level checks for the point-in-polygon-set block
// Watches the command and result ports and checks how busy and result beats
// relate to accepted queries.
// ----------------------------------------------------------------------------
module pic_checker
    import pic_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_pic_in  i_cmd,
    input logic     o_valid,
    input t_pic_out o_res
);

    // Busy only rises after an accepted query.
    a_busy_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ($past(start) && (($past(i_cmd.operation)) == OP_QUERY)))
        else $error("busy rose without an accepted query");

    // A result beat is shown only when the block is ready again.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    // The end of a query walk always delivers its result.
    a_fall_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("query finished without a result beat");

    // A result beat follows a query walk or a query accepted the cycle before.
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || ($past(start) && ($past(i_cmd.operation) == OP_QUERY))))
        else $error("result beat without a query");

    // A miss reports brush zero.
    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.inside_res) |-> (o_res.first_brush_hit == '0))
        else $error("miss with nonzero brush index");

endmodule

bind point_in_convex_polygon_set pic_checker u_pic_checker (.*);
